@@ sv/chip8_pkg.sv @@
// Package with the shared types, codes and constants of the CHIP-8 core.
package chip8_pkg;

   localparam int MEMORY_BYTES = 4096;
   localparam int ADDR_W = 12;
   localparam int SCREEN_WIDTH_DEF = 64;
   localparam int SCREEN_HEIGHT_DEF = 32;
   localparam int STACK_DEPTH_DEF = 16;
   localparam int FONT_BYTES = 80;

   localparam logic [11:0] START_PC = 12'h200;
   localparam logic [7:0] STEPS_RESET = 8'd10;

   localparam logic [2:0] OP_STEP = 3'd0;
   localparam logic [2:0] OP_WRITE_MEM = 3'd1;
   localparam logic [2:0] OP_SET_KEYS = 3'd2;
   localparam logic [2:0] OP_DELIVER_KEY = 3'd3;
   localparam logic [2:0] OP_READ_PIXEL = 3'd4;
   localparam logic [2:0] OP_READ_MEM = 3'd5;

   localparam logic REG_MACHINE_ROUTINE = 1'b0;
   localparam logic REG_STEPS_PER_TICK = 1'b1;

   localparam logic [15:0] INSTR_CLS = 16'h00e0;
   localparam logic [15:0] INSTR_RET = 16'h00ee;
   localparam logic [11:0] SYS_MASK = 12'hffe;
   localparam logic [7:0] KEY_DOWN = 8'h9e;
   localparam logic [7:0] KEY_UP = 8'ha1;
   localparam logic [7:0] FX_GET_DELAY = 8'h07;
   localparam logic [7:0] FX_WAIT_KEY = 8'h0a;
   localparam logic [7:0] FX_SET_DELAY = 8'h15;
   localparam logic [7:0] FX_SET_SOUND = 8'h18;
   localparam logic [7:0] FX_ADD_INDEX = 8'h1e;
   localparam logic [7:0] FX_FONT = 8'h29;
   localparam logic [7:0] FX_BCD = 8'h33;
   localparam logic [7:0] FX_STORE = 8'h55;
   localparam logic [7:0] FX_LOAD = 8'h65;
   localparam logic [7:0] HUNDRED = 8'd100;
   localparam logic [7:0] TEN = 8'd10;

   localparam logic [7:0] FONT [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_OP, ST_READ_WAIT, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE,
      ST_EXEC, ST_FLAG, ST_DRAW_MEM, ST_DRAW_FB, ST_DRAW_WR, ST_BCD, ST_BCD_WR,
      ST_STORE_RD, ST_STORE_WR, ST_LOAD_RD, ST_LOAD_WR, ST_TICK, ST_DONE
   } state_type;

   // Reduces a byte modulo a screen dimension by repeated subtraction.
   function automatic logic [7:0] wrap8(input logic [7:0] v, input logic [7:0] m);
      logic [7:0] r;
      r = v;
      for (int i = 0; i < 8; i++) begin
         if (r >= m) r = r - m;
      end
      return r;
   endfunction

endpackage

@@ sv/chip8_interpreter_core.sv @@
// CHIP-8 processor core: sequencer, register file, memory and framebuffer.
// Host operations pass ST_OP, and ST_READ_WAIT for reads; a step ignored while waiting
// for a key goes to ST_DONE. An instruction is fetched, decoded and executed, and ST_FLAG
// writes VF; a draw loops per sprite row, FX33 per digit, FX55 and FX65 per register.
// One request is in work at a time; the memory and framebuffer ports set the pace.
// Reset clears control state, then a pass loads the font and zeroes memory;
// no request is accepted during that pass.
module chip8_interpreter_core #(
   parameter int SCREEN_WIDTH = chip8_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = chip8_pkg::SCREEN_HEIGHT_DEF,
   parameter int STACK_DEPTH = chip8_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_key_mask,
   input  logic [3:0]  req_key_index,
   input  logic [7:0]  req_random_byte,
   input  logic [5:0]  req_pixel_x,
   input  logic [4:0]  req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_program_counter,
   output logic        rsp_waiting_for_key,
   output logic        rsp_sound_on,
   output logic        rsp_pixel_value,
   output logic [7:0]  rsp_read_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import chip8_pkg::*;

   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);
   localparam int SPW = $clog2(STACK_DEPTH);

   state_type state_ff, state_in;

   logic        mre_ff;
   logic [7:0]  steps_ff;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [11:0] pc_ff, pc_in;
   logic [15:0] index_ff, index_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in, div_ff, div_in;
   logic [15:0] keys_ff, keys_in;
   logic        wait_ff, wait_in;
   logic [3:0]  target_ff, target_in;

   logic [2:0]  op_ff, op_in;
   logic [11:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic [3:0]  kidx_ff, kidx_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [5:0]  px_ff, px_in;
   logic [4:0]  py_ff, py_in;

   logic [7:0]  hi_ff, hi_in;
   logic [15:0] instr_ff, instr_in;
   logic [3:0]  k_ff, k_in;
   logic        hit_ff, hit_in, flag_ff, flag_in;
   logic [7:0]  rem_ff, rem_in;
   logic [3:0]  hund_ff, hund_in, tens_ff, tens_in;
   logic [XW-1:0] x0_ff, x0_in;
   logic [YW-1:0] y0_ff, y0_in, row_ff, row_in;
   logic [7:0]  sprite_ff, sprite_in;
   logic        pix_ff, pix_in;
   logic [7:0]  rd_ff, rd_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] rsp_pc_ff, rsp_pc_in;
   logic        rsp_wait_ff, rsp_wait_in, rsp_snd_ff, rsp_snd_in, rsp_pix_ff, rsp_pix_in;
   logic [7:0]  rsp_rd_ff, rsp_rd_in;

   // Main memory, one write and one registered read port.
   logic [7:0]  mem [MEMORY_BYTES];
   logic        mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]  mem_wdata, mem_q_ff;

   // Data registers, one write and two registered read ports.
   logic [7:0]  vreg [16];
   logic        vvalid_ff [16];
   logic        reg_we;
   logic [3:0]  reg_waddr, reg_ra, reg_rb;
   logic [7:0]  reg_wdata, reg_qa_ff, reg_qb_ff;

   // Framebuffer rows with per-row valid bits so that a clear is immediate.
   logic [SCREEN_WIDTH-1:0] fb [SCREEN_HEIGHT];
   logic        fb_valid_ff [SCREEN_HEIGHT];
   logic        fb_we, fb_clear;
   logic [YW-1:0] fb_waddr, fb_raddr;
   logic [SCREEN_WIDTH-1:0] fb_wdata, fb_q_ff, draw_mask;

   logic [11:0] stack_ff [STACK_DEPTH];
   logic        stack_we;

   logic [SPW-1:0] sp_inc, sp_dec;
   logic [7:0]  vx, vy, nn;
   logic [8:0]  sum9, tick_cnt, period;
   logic [7:0]  ypos;
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_STEPS_PER_TICK) ? {24'd0, steps_ff} : {31'd0, mre_ff};

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_waiting_for_key = rsp_wait_ff;
   assign rsp_sound_on = rsp_snd_ff;
   assign rsp_pixel_value = rsp_pix_ff;
   assign rsp_read_data = rsp_rd_ff;

   assign sp_inc = (sp_ff == SPW'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
   assign sp_dec = (sp_ff == '0) ? SPW'(STACK_DEPTH - 1) : sp_ff - 1'b1;
   assign vx = reg_qa_ff;
   assign vy = reg_qb_ff;
   assign nn = instr_ff[7:0];
   assign sum9 = {1'b0, vx} + {1'b0, vy};
   assign period = (steps_ff == 8'd0) ? 9'd1 : {1'b0, steps_ff};
   assign tick_cnt = {1'b0, div_ff} + 9'd1;
   assign ypos = 8'(y0_ff) + {4'd0, k_ff};

   always_comb begin
      logic [XW:0] pxw;
      draw_mask = '0;
      for (int c = 0; c < 8; c++) begin
         pxw = {1'b0, x0_ff} + (XW+1)'(c);
         if (pxw >= (XW+1)'(SCREEN_WIDTH)) pxw = pxw - (XW+1)'(SCREEN_WIDTH);
         if (sprite_ff[7-c]) draw_mask[pxw[XW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mre_ff <= 1'b0;
         steps_ff <= STEPS_RESET;
      end else if (cfg_wr) begin
         if (paddr[2] == REG_MACHINE_ROUTINE) mre_ff <= pwdata[0];
         else steps_ff <= pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reg_we) vreg[reg_waddr] <= reg_wdata;
      reg_qa_ff <= vvalid_ff[reg_ra] ? vreg[reg_ra] : 8'd0;
      reg_qb_ff <= vvalid_ff[reg_rb] ? vreg[reg_rb] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) vvalid_ff[i] <= 1'b0;
      end else if (reg_we) begin
         vvalid_ff[reg_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fb_we) fb[fb_waddr] <= fb_wdata;
      fb_q_ff <= fb_valid_ff[fb_raddr] ? fb[fb_raddr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || fb_clear) begin
         for (int i = 0; i < SCREEN_HEIGHT; i++) fb_valid_ff[i] <= 1'b0;
      end else if (fb_we) begin
         fb_valid_ff[fb_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= 12'd0;
      end else if (stack_we) begin
         stack_ff[sp_ff] <= pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         pc_ff <= START_PC;
         index_ff <= 16'd0;
         sp_ff <= '0;
         dt_ff <= 8'd0;
         st_ff <= 8'd0;
         div_ff <= 8'd0;
         keys_ff <= 16'd0;
         wait_ff <= 1'b0;
         target_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pc_ff <= pc_in;
         index_ff <= index_in;
         sp_ff <= sp_in;
         dt_ff <= dt_in;
         st_ff <= st_in;
         div_ff <= div_in;
         keys_ff <= keys_in;
         wait_ff <= wait_in;
         target_ff <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
      kidx_ff <= kidx_in;
      rnd_ff <= rnd_in;
      px_ff <= px_in;
      py_ff <= py_in;
      hi_ff <= hi_in;
      instr_ff <= instr_in;
      k_ff <= k_in;
      hit_ff <= hit_in;
      flag_ff <= flag_in;
      rem_ff <= rem_in;
      hund_ff <= hund_in;
      tens_ff <= tens_in;
      x0_ff <= x0_in;
      y0_ff <= y0_in;
      row_ff <= row_in;
      sprite_ff <= sprite_in;
      pix_ff <= pix_in;
      rd_ff <= rd_in;
      rsp_pc_ff <= rsp_pc_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_snd_ff <= rsp_snd_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_rd_ff <= rsp_rd_in;
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      pc_in = pc_ff;
      index_in = index_ff;
      sp_in = sp_ff;
      dt_in = dt_ff;
      st_in = st_ff;
      div_in = div_ff;
      keys_in = keys_ff;
      wait_in = wait_ff;
      target_in = target_ff;
      op_in = op_ff;
      addr_in = addr_ff;
      data_in = data_ff;
      kidx_in = kidx_ff;
      rnd_in = rnd_ff;
      px_in = px_ff;
      py_in = py_ff;
      hi_in = hi_ff;
      instr_in = instr_ff;
      k_in = k_ff;
      hit_in = hit_ff;
      flag_in = flag_ff;
      rem_in = rem_ff;
      hund_in = hund_ff;
      tens_in = tens_ff;
      x0_in = x0_ff;
      y0_in = y0_ff;
      row_in = row_ff;
      sprite_in = sprite_ff;
      pix_in = pix_ff;
      rd_in = rd_ff;
      rsp_pc_in = rsp_pc_ff;
      rsp_wait_in = rsp_wait_ff;
      rsp_snd_in = rsp_snd_ff;
      rsp_pix_in = rsp_pix_ff;
      rsp_rd_in = rsp_rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      mem_we = 1'b0;
      mem_waddr = index_ff[11:0] + {8'd0, k_ff};
      mem_wdata = 8'd0;
      mem_raddr = pc_ff;
      reg_we = 1'b0;
      reg_waddr = instr_ff[11:8];
      reg_wdata = 8'd0;
      reg_ra = instr_ff[11:8];
      reg_rb = instr_ff[7:4];
      fb_we = 1'b0;
      fb_clear = 1'b0;
      fb_waddr = row_ff;
      fb_wdata = fb_q_ff ^ draw_mask;
      fb_raddr = YW'(py_ff);
      stack_we = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (clr_ff < ADDR_W'(FONT_BYTES)) ? FONT[clr_ff[6:0]] : 8'd0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(MEMORY_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               addr_in = req_address;
               data_in = req_data_byte;
               keys_in = (req_operation == OP_SET_KEYS) ? req_key_mask : keys_ff;
               kidx_in = req_key_index;
               rnd_in = req_random_byte;
               px_in = req_pixel_x;
               py_in = req_pixel_y;
               pix_in = 1'b0;
               rd_in = 8'd0;
               if (req_operation == OP_STEP) state_in = wait_ff ? ST_DONE : ST_FETCH_HI;
               else state_in = ST_OP;
            end
         end
         ST_OP: begin
            state_in = ST_DONE;
            case (op_ff)
               OP_WRITE_MEM: begin
                  mem_we = 1'b1;
                  mem_waddr = addr_ff;
                  mem_wdata = data_ff;
               end
               OP_DELIVER_KEY: begin
                  if (wait_ff) begin
                     reg_we = 1'b1;
                     reg_waddr = target_ff;
                     reg_wdata = {4'd0, kidx_ff};
                     wait_in = 1'b0;
                  end
               end
               OP_READ_PIXEL: state_in = ST_READ_WAIT;
               OP_READ_MEM: begin
                  mem_raddr = addr_ff;
                  state_in = ST_READ_WAIT;
               end
               default: ;
            endcase
         end
         ST_READ_WAIT: begin
            if (op_ff == OP_READ_PIXEL)
               pix_in = (px_ff < SCREEN_WIDTH) && (py_ff < SCREEN_HEIGHT) && fb_q_ff[XW'(px_ff)];
            else
               rd_in = mem_q_ff;
            state_in = ST_DONE;
         end
         ST_FETCH_HI: begin
            mem_raddr = pc_ff;
            state_in = ST_FETCH_LO;
         end
         ST_FETCH_LO: begin
            mem_raddr = pc_ff + 12'd1;
            hi_in = mem_q_ff;
            state_in = ST_DECODE;
         end
         ST_DECODE: begin
            instr_in = {hi_ff, mem_q_ff};
            pc_in = pc_ff + 12'd2;
            reg_ra = hi_ff[3:0];
            // BNNN needs V0 on the second port instead of VY.
            reg_rb = (hi_ff[7:4] == 4'hb) ? 4'd0 : mem_q_ff[7:4];
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_TICK;
            case (instr_ff[15:12])
               4'h0: begin
                  if (instr_ff == INSTR_CLS) fb_clear = 1'b1;
                  else if (instr_ff == INSTR_RET) begin
                     sp_in = sp_dec;
                     pc_in = stack_ff[sp_dec];
                  end else if (mre_ff) pc_in = instr_ff[11:0] & SYS_MASK;
               end
               4'h1: pc_in = instr_ff[11:0];
               4'h2: begin
                  stack_we = 1'b1;
                  sp_in = sp_inc;
                  pc_in = instr_ff[11:0];
               end
               4'h3: if (vx == nn) pc_in = pc_ff + 12'd2;
               4'h4: if (vx != nn) pc_in = pc_ff + 12'd2;
               4'h5: if (instr_ff[3:0] == 4'd0 && vx == vy) pc_in = pc_ff + 12'd2;
               4'h6: begin
                  reg_we = 1'b1;
                  reg_wdata = nn;
               end
               4'h7: begin
                  reg_we = 1'b1;
                  reg_wdata = vx + nn;
               end
               4'h8: begin
                  case (instr_ff[3:0])
                     4'h0: begin reg_we = 1'b1; reg_wdata = vy; end
                     4'h1: begin reg_we = 1'b1; reg_wdata = vx | vy; end
                     4'h2: begin reg_we = 1'b1; reg_wdata = vx & vy; end
                     4'h3: begin reg_we = 1'b1; reg_wdata = vx ^ vy; end
                     4'h4: begin
                        reg_we = 1'b1; reg_wdata = sum9[7:0];
                        flag_in = sum9[8]; state_in = ST_FLAG;
                     end
                     4'h5: begin
                        reg_we = 1'b1; reg_wdata = vx - vy;
                        flag_in = (vx >= vy); state_in = ST_FLAG;
                     end
                     4'h6: begin
                        reg_we = 1'b1; reg_wdata = {1'b0, vx[7:1]};
                        flag_in = vx[0]; state_in = ST_FLAG;
                     end
                     4'h7: begin
                        reg_we = 1'b1; reg_wdata = vy - vx;
                        flag_in = (vx <= vy); state_in = ST_FLAG;
                     end
                     4'he: begin
                        reg_we = 1'b1; reg_wdata = {vx[6:0], 1'b0};
                        flag_in = vx[7]; state_in = ST_FLAG;
                     end
                     default: ;
                  endcase
               end
               4'h9: if (instr_ff[3:0] == 4'd0 && vx != vy) pc_in = pc_ff + 12'd2;
               4'ha: index_in = {4'd0, instr_ff[11:0]};
               4'hb: pc_in = instr_ff[11:0] + {4'd0, vy};
               4'hc: begin
                  reg_we = 1'b1;
                  reg_wdata = rnd_ff & nn;
               end
               4'hd: begin
                  x0_in = XW'(wrap8(vx, 8'(SCREEN_WIDTH)));
                  y0_in = YW'(wrap8(vy, 8'(SCREEN_HEIGHT)));
                  k_in = 4'd0;
                  hit_in = 1'b0;
                  flag_in = 1'b0;
                  state_in = (instr_ff[3:0] == 4'd0) ? ST_FLAG : ST_DRAW_MEM;
               end
               4'he: begin
                  if (nn == KEY_DOWN && keys_ff[vx[3:0]]) pc_in = pc_ff + 12'd2;
                  else if (nn == KEY_UP && !keys_ff[vx[3:0]]) pc_in = pc_ff + 12'd2;
               end
               default: begin
                  case (nn)
                     FX_GET_DELAY: begin reg_we = 1'b1; reg_wdata = dt_ff; end
                     FX_WAIT_KEY: begin wait_in = 1'b1; target_in = instr_ff[11:8]; end
                     FX_SET_DELAY: dt_in = vx;
                     FX_SET_SOUND: st_in = vx;
                     FX_ADD_INDEX: index_in = index_ff + {8'd0, vx};
                     FX_FONT: index_in = {6'd0, vx, 2'd0} + {8'd0, vx};
                     FX_BCD: begin
                        rem_in = vx; hund_in = 4'd0; tens_in = 4'd0;
                        state_in = ST_BCD;
                     end
                     FX_STORE: begin k_in = 4'd0; state_in = ST_STORE_RD; end
                     FX_LOAD: begin k_in = 4'd0; state_in = ST_LOAD_RD; end
                     default: ;
                  endcase
               end
            endcase
         end
         ST_FLAG: begin
            reg_we = 1'b1;
            reg_waddr = 4'hf;
            reg_wdata = {7'd0, flag_ff};
            state_in = ST_TICK;
         end
         ST_DRAW_MEM: begin
            mem_raddr = index_ff[11:0] + {8'd0, k_ff};
            state_in = ST_DRAW_FB;
         end
         ST_DRAW_FB: begin
            sprite_in = mem_q_ff;
            if (ypos >= 8'(SCREEN_HEIGHT)) row_in = YW'(ypos - 8'(SCREEN_HEIGHT));
            else row_in = YW'(ypos);
            fb_raddr = row_in;
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            fb_we = 1'b1;
            hit_in = hit_ff || ((fb_q_ff & draw_mask) != '0);
            k_in = k_ff + 4'd1;
            if (k_ff + 4'd1 == instr_ff[3:0]) begin
               flag_in = hit_in;
               state_in = ST_FLAG;
            end else begin
               state_in = ST_DRAW_MEM;
            end
         end
         ST_BCD: begin
            // The digits are peeled off by repeated subtraction of 100, then of 10.
            if (rem_ff >= HUNDRED) begin
               rem_in = rem_ff - HUNDRED;
               hund_in = hund_ff + 4'd1;
            end else if (rem_ff >= TEN) begin
               rem_in = rem_ff - TEN;
               tens_in = tens_ff + 4'd1;
            end else begin
               k_in = 4'd0;
               state_in = ST_BCD_WR;
            end
         end
         ST_BCD_WR: begin
            mem_we = 1'b1;
            mem_wdata = (k_ff == 4'd0) ? {4'd0, hund_ff} :
                        (k_ff == 4'd1) ? {4'd0, tens_ff} : rem_ff;
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd2) state_in = ST_TICK;
         end
         ST_STORE_RD: begin
            reg_ra = k_ff;
            state_in = ST_STORE_WR;
         end
         ST_STORE_WR: begin
            mem_we = 1'b1;
            mem_wdata = reg_qa_ff;
            k_in = k_ff + 4'd1;
            state_in = (k_ff == instr_ff[11:8]) ? ST_TICK : ST_STORE_RD;
         end
         ST_LOAD_RD: begin
            mem_raddr = index_ff[11:0] + {8'd0, k_ff};
            state_in = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            reg_we = 1'b1;
            reg_waddr = k_ff;
            reg_wdata = mem_q_ff;
            k_in = k_ff + 4'd1;
            state_in = (k_ff == instr_ff[11:8]) ? ST_TICK : ST_LOAD_RD;
         end
         ST_TICK: begin
            if (tick_cnt >= period) begin
               div_in = 8'd0;
               if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
               if (st_ff != 8'd0) st_in = st_ff - 8'd1;
            end else begin
               div_in = tick_cnt[7:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pc_in = pc_ff;
               rsp_wait_in = wait_ff;
               rsp_snd_in = (st_ff != 8'd0);
               rsp_pix_in = pix_ff;
               rsp_rd_in = rd_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ sim/chip8_core_checker.sv @@
// Checker for the CHIP-8 core: predicts every response and compares it with the DUT.
module chip8_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_key_mask,
   input  logic [3:0]  req_key_index,
   input  logic [7:0]  req_random_byte,
   input  logic [5:0]  req_pixel_x,
   input  logic [4:0]  req_pixel_y,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [11:0] rsp_program_counter,
   input  logic        rsp_waiting_for_key,
   input  logic        rsp_sound_on,
   input  logic        rsp_pixel_value,
   input  logic [7:0]  rsp_read_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending
);
   import chip8_pkg::*;

   typedef struct packed {
      logic [11:0] pc;
      logic        waiting;
      logic        sound;
      logic        pixel;
      logic [7:0]  rdata;
   } core_status_type;

   localparam int SCR_W = SCREEN_WIDTH_DEF;
   localparam int SCR_H = SCREEN_HEIGHT_DEF;
   localparam int STK_D = STACK_DEPTH_DEF;

   core_status_type status_q[$];

   logic [7:0]  mem [MEMORY_BYTES];
   logic [7:0]  vreg [16];
   logic [15:0] index_reg;
   logic [11:0] pc;
   logic [11:0] stack [STK_D];
   int          sp;
   logic [7:0]  delay_t, sound_t, tick_div;
   logic        screen [SCR_W * SCR_H];
   logic [15:0] keys;
   logic        key_wait;
   logic [3:0]  wait_reg;
   logic        routine_en;
   logic [7:0]  tick_period;

   assign pending = status_q.size();

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0h, expected %0h (%0t)", what, got, want, $time);
      fail_count++;
   endtask

   task automatic model_reset();
      for (int i = 0; i < MEMORY_BYTES; i++) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
      for (int i = 0; i < 16; i++) vreg[i] = 8'h00;
      for (int i = 0; i < STK_D; i++) stack[i] = 12'h000;
      for (int i = 0; i < SCR_W * SCR_H; i++) screen[i] = 1'b0;
      index_reg = 16'h0;
      pc = START_PC;
      sp = 0;
      delay_t = 0;
      sound_t = 0;
      tick_div = 0;
      keys = 0;
      key_wait = 0;
      wait_reg = 0;
      routine_en = 0;
      tick_period = STEPS_RESET;
   endtask

   task automatic skip_when(input logic cond);
      if (cond) pc = pc + 12'd2;
   endtask

   task automatic run_instruction(input logic [7:0] rnd);
      logic [15:0] ins;
      logic [3:0]  x, y, n;
      logic [7:0]  nn, vx, vy;
      logic        fl;
      logic [11:0] nnn;
      int          x0, y0, py, px, period, cnt;
      logic [7:0]  bits;
      logic        hit;
      ins = {mem[pc], mem[pc + 12'd1]};
      x = ins[11:8];
      y = ins[7:4];
      n = ins[3:0];
      nn = ins[7:0];
      nnn = ins[11:0];
      vx = vreg[x];
      vy = vreg[y];
      pc = pc + 12'd2;
      case (ins[15:12])
         4'h0: begin
            if (ins == INSTR_CLS) begin
               for (int i = 0; i < SCR_W * SCR_H; i++) screen[i] = 1'b0;
            end else if (ins == INSTR_RET) begin
               sp = (sp + STK_D - 1) % STK_D;
               pc = stack[sp];
            end else if (routine_en) begin
               pc = nnn & SYS_MASK;
            end
         end
         4'h1: pc = nnn;
         4'h2: begin
            stack[sp] = pc;
            sp = (sp + 1) % STK_D;
            pc = nnn;
         end
         4'h3: skip_when(vx == nn);
         4'h4: skip_when(vx != nn);
         4'h5: if (n == 0) skip_when(vx == vy);
         4'h6: vreg[x] = nn;
         4'h7: vreg[x] = vx + nn;
         4'h8: begin
            case (n)
               4'h0: vreg[x] = vy;
               4'h1: vreg[x] = vx | vy;
               4'h2: vreg[x] = vx & vy;
               4'h3: vreg[x] = vx ^ vy;
               4'h4: begin
                  fl = ({1'b0, vx} + {1'b0, vy} > 9'h0ff);
                  vreg[x] = vx + vy;
                  vreg[15] = {7'h0, fl};
               end
               4'h5: begin
                  fl = (vx >= vy);
                  vreg[x] = vx - vy;
                  vreg[15] = {7'h0, fl};
               end
               4'h6: begin
                  fl = vx[0];
                  vreg[x] = vx >> 1;
                  vreg[15] = {7'h0, fl};
               end
               4'h7: begin
                  fl = (vx <= vy);
                  vreg[x] = vy - vx;
                  vreg[15] = {7'h0, fl};
               end
               4'he: begin
                  fl = vx[7];
                  vreg[x] = vx << 1;
                  vreg[15] = {7'h0, fl};
               end
               default: ;
            endcase
         end
         4'h9: if (n == 0) skip_when(vx != vy);
         4'ha: index_reg = {4'h0, nnn};
         4'hb: pc = nnn + {4'h0, vreg[0]};
         4'hc: vreg[x] = rnd & nn;
         4'hd: begin
            x0 = vx % SCR_W;
            y0 = vy % SCR_H;
            hit = 0;
            for (int r = 0; r < n; r++) begin
               bits = mem[12'(index_reg + r)];
               py = (y0 + r) % SCR_H;
               for (int c = 0; c < 8; c++) begin
                  if (bits[7 - c]) begin
                     px = (x0 + c) % SCR_W;
                     if (screen[py * SCR_W + px]) hit = 1;
                     screen[py * SCR_W + px] = !screen[py * SCR_W + px];
                  end
               end
            end
            vreg[15] = {7'h0, hit};
         end
         4'he: begin
            if (nn == KEY_DOWN) skip_when(keys[vx[3:0]]);
            else if (nn == KEY_UP) skip_when(!keys[vx[3:0]]);
         end
         default: begin
            case (nn)
               FX_GET_DELAY: vreg[x] = delay_t;
               FX_WAIT_KEY: begin
                  key_wait = 1;
                  wait_reg = x;
               end
               FX_SET_DELAY: delay_t = vx;
               FX_SET_SOUND: sound_t = vx;
               FX_ADD_INDEX: index_reg = index_reg + {8'h0, vx};
               FX_FONT: index_reg = {8'h0, vx} * 16'd5;
               FX_BCD: begin
                  mem[12'(index_reg)] = vx / HUNDRED;
                  mem[12'(index_reg + 1)] = (vx / TEN) % TEN;
                  mem[12'(index_reg + 2)] = vx % TEN;
               end
               FX_STORE: for (int k = 0; k <= x; k++) mem[12'(index_reg + k)] = vreg[k];
               FX_LOAD: for (int k = 0; k <= x; k++) vreg[k] = mem[12'(index_reg + k)];
               default: ;
            endcase
         end
      endcase
      period = (tick_period == 0) ? 1 : tick_period;
      cnt = tick_div + 1;
      if (cnt >= period) begin
         cnt = 0;
         if (delay_t != 0) delay_t--;
         if (sound_t != 0) sound_t--;
      end
      tick_div = 8'(cnt);
   endtask

   task automatic predict_request();
      core_status_type s;
      s = '0;
      case (req_operation)
         OP_STEP: if (!key_wait) run_instruction(req_random_byte);
         OP_WRITE_MEM: mem[req_address] = req_data_byte;
         OP_SET_KEYS: keys = req_key_mask;
         OP_DELIVER_KEY: begin
            if (key_wait) begin
               vreg[wait_reg] = {4'h0, req_key_index};
               key_wait = 0;
            end
         end
         OP_READ_PIXEL: begin
            if (req_pixel_x < SCR_W && req_pixel_y < SCR_H)
               s.pixel = screen[req_pixel_y * SCR_W + req_pixel_x];
         end
         OP_READ_MEM: s.rdata = mem[req_address];
         default: ;
      endcase
      s.pc = pc;
      s.waiting = key_wait;
      s.sound = (sound_t != 0);
      status_q.push_back(s);
   endtask

   always @(posedge clock) begin
      core_status_type want;
      if (reset) begin
         model_reset();
         status_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               report("response without request", rsp_program_counter, 0);
            end else begin
               want = status_q.pop_front();
               if (rsp_program_counter !== want.pc)
                  report("program_counter", rsp_program_counter, want.pc);
               if (rsp_waiting_for_key !== want.waiting)
                  report("waiting_for_key", rsp_waiting_for_key, want.waiting);
               if (rsp_sound_on !== want.sound)
                  report("sound_on", rsp_sound_on, want.sound);
               if (rsp_pixel_value !== want.pixel)
                  report("pixel_value", rsp_pixel_value, want.pixel);
               if (rsp_read_data !== want.rdata)
                  report("read_data", rsp_read_data, want.rdata);
            end
         end
         if (req_valid && req_ready) predict_request();
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_MACHINE_ROUTINE, 2'b00}) routine_en = pwdata[0];
            else if (paddr == {REG_STEPS_PER_TICK, 2'b00}) tick_period = pwdata[7:0];
         end
      end
   end

endmodule

@@ sim/tb_chip8_interpreter_core.sv @@
// Testbench top: drives programs, host requests and register writes into the CHIP-8 core.
module tb_chip8_interpreter_core;
   import chip8_pkg::*;

   localparam int ITEM_TARGET = 1150;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_operation = 0;
   logic [11:0] req_address = 0;
   logic [7:0]  req_data_byte = 0;
   logic [15:0] req_key_mask = 0;
   logic [3:0]  req_key_index = 0;
   logic [7:0]  req_random_byte = 0;
   logic [5:0]  req_pixel_x = 0;
   logic [4:0]  req_pixel_y = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [11:0] rsp_program_counter;
   logic        rsp_waiting_for_key;
   logic        rsp_sound_on;
   logic        rsp_pixel_value;
   logic [7:0]  rsp_read_data;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   int          fail_count, pending;
   int          items_sent = 0, instr_built = 0, rsp_seen = 0, quiet_cycles = 0;
   logic [11:0] last_pc = START_PC;
   logic        last_wait = 0;
   logic        no_gaps = 0;
   int          rsp_stall = 0;

   chip8_interpreter_core u_top (.*);

   chip8_core_checker u_checker (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The response side stalls in random stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1;
         if (rsp_ready && $urandom_range(0, 3) == 0) rsp_stall <= gap_len();
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         last_pc <= rsp_program_counter;
         last_wait <= rsp_waiting_for_key;
         rsp_seen <= rsp_seen + 1;
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Unused fields carry random values so every bit of every field toggles.
   task automatic send(input logic [2:0] op, input logic [11:0] addr, input logic [7:0] dbyte);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_address <= addr;
      req_data_byte <= dbyte;
      req_key_mask <= 16'($urandom);
      req_key_index <= 4'($urandom);
      req_random_byte <= 8'($urandom);
      req_pixel_x <= 6'($urandom);
      req_pixel_y <= 5'($urandom);
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // A final clock wait lets the last response settle into last_pc and last_wait.
   task automatic drain();
      req_valid <= 0;
      do @(posedge clock); while (pending != 0 || req_valid);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   function automatic logic [15:0] pick_instr();
      logic [3:0]  grp;
      logic [11:0] low;
      logic [7:0]  fx_codes [10];
      fx_codes = '{FX_GET_DELAY, FX_WAIT_KEY, FX_SET_DELAY, FX_SET_SOUND, FX_ADD_INDEX,
                   FX_FONT, FX_BCD, FX_STORE, FX_LOAD, 8'h00};
      grp = 4'($urandom);
      low = 12'($urandom);
      case (grp)
         4'h0: begin
            case ($urandom_range(0, 2))
               0: return INSTR_CLS;
               1: return INSTR_RET;
               default: return {4'h0, low};
            endcase
         end
         4'h5, 4'h9: if ($urandom_range(0, 4) != 0) low[3:0] = 4'h0;
         4'h8: if ($urandom_range(0, 5) != 0) low[3:0] = ($urandom_range(0, 8) == 8) ?
                  4'he : 4'($urandom_range(0, 7));
         4'he: if ($urandom_range(0, 5) != 0) low[7:0] = $urandom_range(0, 1) ? KEY_DOWN : KEY_UP;
         4'hf: if ($urandom_range(0, 7) != 0) begin
            low[7:0] = fx_codes[$urandom_range(0, 8)];
            // Half of the key waits become sound timer writes so waits stay occasional.
            if (low[7:0] == FX_WAIT_KEY && $urandom_range(0, 1)) low[7:0] = FX_SET_SOUND;
         end
         default: ;
      endcase
      return {grp, low};
   endfunction

   // Places one instruction at the current program counter and executes it.
   task automatic run_one(input logic [15:0] ins);
      drain();
      if (last_wait) begin
         if ($urandom_range(0, 1)) send(OP_STEP, 12'($urandom), 8'($urandom));
         send(OP_DELIVER_KEY, 12'($urandom), 8'($urandom));
         drain();
      end
      send(OP_WRITE_MEM, last_pc, ins[15:8]);
      send(OP_WRITE_MEM, last_pc + 12'd1, ins[7:0]);
      send(OP_STEP, 12'($urandom), 8'($urandom));
      instr_built++;
   endtask

   task automatic noise_item();
      logic [2:0] op;
      op = 3'($urandom);
      send(op, 12'($urandom), 8'($urandom));
   endtask

   initial begin
      logic        mre_set [7];
      logic [7:0]  tick_set [7];
      mre_set = '{0, 1, 0, 1, 0, 1, 1};
      tick_set = '{10, 1, 255, 3, 1, 255, 7};
      repeat (12) @(posedge clock);
      reset <= 0;

      // Directed: memory corners, a random pixel read, key requests, idle operations.
      send(OP_READ_MEM, 12'h000, 8'h00);
      send(OP_READ_MEM, 12'h04f, 8'h00);
      send(OP_READ_MEM, 12'hfff, 8'h00);
      send(OP_WRITE_MEM, 12'hfff, 8'hff);
      send(OP_READ_MEM, 12'hfff, 8'h00);
      send(OP_WRITE_MEM, 12'h000, 8'h00);
      send(OP_READ_PIXEL, 12'h000, 8'h00);
      send(OP_SET_KEYS, 12'h000, 8'h00);
      send(OP_DELIVER_KEY, 12'h000, 8'h00);
      send(3'd6, 12'h000, 8'h00);
      send(3'd7, 12'hfff, 8'hff);
      send(OP_STEP, 12'h000, 8'h00);
      drain();
      run_one(16'h6f05);
      run_one(16'hd005);
      run_one(16'hd005);
      run_one({4'hf, 4'h3, FX_WAIT_KEY});
      run_one(16'h8f3e);

      for (int ph = 0; ph < 7; ph++) begin
         drain();
         csr_write({REG_MACHINE_ROUTINE, 2'b00}, {31'h0, mre_set[ph]});
         csr_write({REG_STEPS_PER_TICK, 2'b00}, {24'h0, tick_set[ph]});
         while (items_sent < ITEM_TARGET * (ph + 1) / 7) begin
            no_gaps = ($urandom_range(0, 9) < 2);
            if ($urandom_range(0, 3) == 0) noise_item();
            else run_one(pick_instr());
         end
      end
      drain();
      repeat (40) @(posedge clock);
      $display("Covered %0d requests, %0d program instructions, %0d responses checked.",
               items_sent, instr_built, rsp_seen);
      $display("Register settings exercised: 7, including timer periods 1 and 255.");
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/chip8_pkg.sv
sv/chip8_interpreter_core.sv
sim/chip8_core_checker.sv
sim/tb_chip8_interpreter_core.sv
